### rtl/pvd_pkg.sv
// ----------------------------------------------------------------------------
// pvd_pkg
// Types and constants shared by the prefix varint decoder and its channels.
// ----------------------------------------------------------------------------
package pvd_pkg;

   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 64;
   localparam int COUNT_W = 4;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0] count_type;

   // Number of following bytes for each multi-byte form.
   localparam count_type FOLLOW_ONE   = 4'd1;
   localparam count_type FOLLOW_TWO   = 4'd2;
   localparam count_type FOLLOW_THREE = 4'd3;
   localparam count_type FOLLOW_FOUR  = 4'd4;
   localparam count_type FOLLOW_EIGHT = 4'd8;
   localparam count_type FOLLOW_NONE  = 4'd0;

endpackage

### rtl/pvd_if.sv
// ----------------------------------------------------------------------------
// pvd_if
// Valid/ready channels for encoded bytes in and decoded values out.
// ----------------------------------------------------------------------------
interface pvd_req_if import pvd_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     buffer_end;

   modport source (output valid, data_byte, buffer_end, input ready);
   modport sink   (input valid, data_byte, buffer_end, output ready);
endinterface

interface pvd_rsp_if import pvd_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type value;
   logic      truncated;

   modport source (output valid, value, truncated, input ready);
   modport sink   (input valid, value, truncated, output ready);
endinterface

### rtl/prefix_varint_stream_decoder.sv
// ----------------------------------------------------------------------------
// prefix_varint_stream_decoder
// Takes one encoded byte per word and emits a decoded 64-bit value, with a
// truncation flag, whenever a value completes or the buffer ends inside one.
// The decoder accepts one byte every clock cycle as long as the output
// register is empty or being drained in the same cycle; a result enters
// the output register in the cycle after the byte that completes it. The
// single output register is what limits throughput: while a result sits
// unread, further bytes wait.
// ----------------------------------------------------------------------------
module prefix_varint_stream_decoder import pvd_pkg::*; (
   input logic            clock,
   input logic            reset,
   pvd_req_if.sink        req_if,
   pvd_rsp_if.source      rsp_if
);

   count_type rem_ff, rem_in;
   value_type acc_ff, acc_in;
   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_value_ff;
   logic      rsp_trunc_ff;

   logic      accept;
   logic      emit;
   value_type emit_value;
   logic      emit_trunc;
   value_type acc_shift;
   count_type rem_dec;
   byte_type  b;

   assign req_if.ready     = !rsp_valid_ff || rsp_if.ready;
   assign accept           = req_if.valid && req_if.ready;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.value     = rsp_value_ff;
   assign rsp_if.truncated = rsp_trunc_ff;

   assign b         = req_if.data_byte;
   assign acc_shift = {acc_ff[VALUE_W-BYTE_W-1:0], b};
   assign rem_dec   = rem_ff - 4'd1;

   always_comb begin
      emit       = 1'b0;
      emit_value = '0;
      emit_trunc = 1'b0;
      rem_in     = rem_ff;
      acc_in     = acc_ff;
      if (rem_ff != FOLLOW_NONE) begin
         acc_in = acc_shift;
         rem_in = rem_dec;
         if (rem_dec == FOLLOW_NONE) begin
            emit       = 1'b1;
            emit_value = acc_shift;
         end else if (req_if.buffer_end) begin
            emit       = 1'b1;
            emit_trunc = 1'b1;
         end
      end else begin
         unique case (b) inside
            8'b0???????: begin
               emit       = 1'b1;
               emit_value = {{(VALUE_W-BYTE_W){1'b0}}, b};
            end
            8'b10??????: begin
               acc_in = {{(VALUE_W-6){1'b0}}, b[5:0]};
               rem_in = FOLLOW_ONE;
            end
            8'b110?????: begin
               acc_in = {{(VALUE_W-5){1'b0}}, b[4:0]};
               rem_in = FOLLOW_TWO;
            end
            8'b1110????: begin
               acc_in = {{(VALUE_W-4){1'b0}}, b[3:0]};
               rem_in = FOLLOW_THREE;
            end
            8'b111100??: begin
               acc_in = '0;
               rem_in = FOLLOW_FOUR;
            end
            8'b111101??: begin
               acc_in = '0;
               rem_in = FOLLOW_EIGHT;
            end
            default: begin
               emit       = 1'b1;
               emit_value = {{(VALUE_W-2){1'b1}}, ~b[1:0]};
            end
         endcase
         // A multi-byte form that meets the end of the buffer is cut short.
         if (!emit && req_if.buffer_end) begin
            emit       = 1'b1;
            emit_trunc = 1'b1;
         end
      end
      if (emit) begin
         rem_in = FOLLOW_NONE;
         acc_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= FOLLOW_NONE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            rem_ff <= rem_in;
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_value_ff <= emit_value;
         rsp_trunc_ff <= emit_trunc;
      end
   end

`ifndef ASSERT_OFF
   a_trunc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_trunc_ff |-> rsp_value_ff == '0)
      else $error("truncated word carries a nonzero value");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= FOLLOW_EIGHT)
      else $error("byte count out of range");

   a_last_follow: assert property (@(posedge clock) disable iff (reset)
      accept && rem_ff == FOLLOW_ONE |=> rsp_valid_ff)
      else $error("final following byte gave no result");

   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.buffer_end |=> rem_ff == FOLLOW_NONE)
      else $error("decoder not idle after end of buffer");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives encoded byte streams into the prefix varint decoder and checks every
// decoded value and truncation flag against a behavioral decoder kept in the
// bench. A directed list covers each prefix form and the truncation cases,
// then random well-formed values mixed with noise run under several idling
// and back-pressure phases.
// ----------------------------------------------------------------------------
module tb_top;
   import pvd_pkg::*;

   typedef struct {
      value_type value;
      logic      truncated;
   } decoded_type;

   class varint_tracker;
      count_type   bytes_left;
      value_type   partial;
      decoded_type expected_values[$];
      int          error_count;

      function new();
         bytes_left  = FOLLOW_NONE;
         partial     = '0;
         error_count = 0;
      endfunction

      function void flag(string msg);
         error_count++;
         if (error_count <= 10) begin
            $display("%s", msg);
         end
      endfunction

      function void finish_value(value_type v, logic trunc);
         decoded_type d;
         d.value     = v;
         d.truncated = trunc;
         expected_values.push_back(d);
         bytes_left = FOLLOW_NONE;
         partial    = '0;
      endfunction

      function int outstanding();
         return expected_values.size();
      endfunction

      // Mirrors the decoder state for one accepted byte.
      function void note_byte(byte_type b, logic last);
         if (bytes_left != FOLLOW_NONE) begin
            partial    = {partial[VALUE_W-BYTE_W-1:0], b};
            bytes_left = bytes_left - 4'd1;
            if (bytes_left == FOLLOW_NONE) begin
               finish_value(partial, 1'b0);
            end else if (last) begin
               finish_value('0, 1'b1);
            end
            return;
         end
         casez (b)
            8'b0???????: begin
               finish_value(value_type'(b), 1'b0);
               return;
            end
            8'b10??????: begin
               partial    = value_type'(b[5:0]);
               bytes_left = FOLLOW_ONE;
            end
            8'b110?????: begin
               partial    = value_type'(b[4:0]);
               bytes_left = FOLLOW_TWO;
            end
            8'b1110????: begin
               partial    = value_type'(b[3:0]);
               bytes_left = FOLLOW_THREE;
            end
            8'b111100??: begin
               partial    = '0;
               bytes_left = FOLLOW_FOUR;
            end
            8'b111101??: begin
               partial    = '0;
               bytes_left = FOLLOW_EIGHT;
            end
            default: begin
               // Short forms: the inverse of the two low bits, all 64 bits wide.
               finish_value(~value_type'(b[1:0]), 1'b0);
               return;
            end
         endcase
         if (last) begin
            finish_value('0, 1'b1);
         end
      endfunction

      function void check_result(value_type v, logic trunc);
         decoded_type d;
         if (expected_values.size() == 0) begin
            flag($sformatf("unexpected result: value=%h truncated=%b", v, trunc));
            return;
         end
         d = expected_values.pop_front();
         if (v !== d.value) begin
            flag($sformatf("value mismatch: expected %h, got %h", d.value, v));
         end
         if (trunc !== d.truncated) begin
            flag($sformatf("truncated mismatch: expected %b, got %b",
                           d.truncated, trunc));
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   pvd_req_if req_bus ();
   pvd_rsp_if rsp_bus ();

   prefix_varint_stream_decoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   varint_tracker tracker = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int sent_count     = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.data_byte   = '0;
      req_bus.buffer_end  = 1'b0;
      rsp_bus.ready       = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver: a long hold-off takes priority over the random stalls.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            tracker.check_result(rsp_bus.value, rsp_bus.truncated);
         end
      end
   end

   // Called just after a falling edge; returns just after a falling edge with
   // the word accepted and valid still high.
   task automatic send_byte(byte_type b, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= b;
      req_bus.buffer_end <= last;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_byte(b, last);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_random_value();
      int       form;
      int       follow;
      int       cut;
      byte_type lead;
      byte_type b;
      logic     last;
      form   = $urandom_range(9);
      follow = 0;
      case (form)
         0, 1: lead = byte_type'($urandom_range(127));
         2: begin lead = {2'b10, 6'($urandom)};     follow = 1; end
         3: begin lead = {3'b110, 5'($urandom)};    follow = 2; end
         4: begin lead = {4'b1110, 4'($urandom)};   follow = 3; end
         5: begin lead = {6'b111100, 2'($urandom)}; follow = 4; end
         6: begin lead = {6'b111101, 2'($urandom)}; follow = 8; end
         7: lead = {5'b11111, 3'($urandom)};
         default: begin
            // Noise: any byte, any buffer end, wherever the decoder happens to be.
            send_byte(byte_type'($urandom), 1'($urandom));
            return;
         end
      endcase
      cut = -1;
      if (follow > 0 && $urandom_range(9) == 0) begin
         cut = $urandom_range(follow - 1);
      end
      for (int i = 0; i <= follow; i++) begin
         b    = (i == 0) ? lead : byte_type'($urandom);
         last = (i == cut) || (i == follow && $urandom_range(3) == 0);
         send_byte(b, last);
         if (i == cut) begin
            break;
         end
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (tracker.outstanding() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   initial begin
      int phase_target;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: every form, its extremes and the truncation cases.
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hDF, 1'b0);
      send_byte(8'hAB, 1'b1);
      send_byte(8'hE5, 1'b1);
      send_byte(8'hE0, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b1);
      // Four-byte form with stray low bits in the leading byte.
      send_byte(8'hF3, 1'b0);
      repeat (3) send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hF7, 1'b0);
      send_byte(8'h80, 1'b0);
      repeat (6) send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hFC, 1'b0);
      send_byte(8'hFB, 1'b1);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; hold_left = 300; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         phase_target = sent_count + 480;
         while (sent_count < phase_target) begin
            send_random_value();
         end
         drain_results();
      end

      repeat (10) @(posedge clock);
      if (tracker.outstanding() != 0) begin
         tracker.flag("results still expected at end of run");
      end
      if (tracker.error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
